FILE: rtl/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Shared types and constants for the SipHash-2-4 stream hasher: the chain
// state type, the initialization constants and the byte mask helper.
// ----------------------------------------------------------------------------
package sip_pkg;

    typedef logic [63:0]     word_t;
    typedef word_t [3:0]     state_t;

    // Initialization constants, XORed with the key halves at message start
    localparam word_t SIP_C0 = 64'h736f6d6570736575;
    localparam word_t SIP_C1 = 64'h646f72616e646f6d;
    localparam word_t SIP_C2 = 64'h6c7967656e657261;
    localparam word_t SIP_C3 = 64'h7465646279746573;

    // Finalization tweak applied to chain word 2
    localparam word_t SIP_FIN_XOR = 64'h00000000000000ff;

    // Round counts
    localparam logic [2:0] C_ROUNDS = 3'd2;
    localparam logic [2:0] D_ROUNDS = 3'd4;

    // Register indexes of the configuration port
    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    // Mask that keeps the low n bytes of a word (n in 0..8)
    function automatic word_t low_bytes(input logic [3:0] n);
        word_t mask;
        mask = '0;
        for (int i = 0; i < 8; i++) begin
            mask[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
        end
        return mask;
    endfunction

endpackage

FILE: rtl/siphash_2_4_stream.sv
// ----------------------------------------------------------------------------
// siphash_2_4_stream
// SipHash-2-4 over a message streamed as 64-bit little-endian words, keyed
// by two 64-bit configuration registers. One SipRound unit is reused under a
// small sequencer; the digest waits in an output register.
//
//   channel   dir  handshake             payload
//   input     in   in_valid / in_ready   message_word, byte_count, last_word
//   output    out  out_valid / out_ready digest
//   config    in   cfg_we                cfg_index, cfg_data
//
// A non-last word is accepted and then absorbed with two rounds.
// A last item with 0..7 bytes runs 2 + 4 rounds; a last item with 8 bytes
// runs two more rounds first, since an extra length block is absorbed.
// Rounds run one per cycle through the single shared round unit, save the
// last finalization round, which holds while the output register is full.
// Reset clears the keys, the message length and the in-progress flag.
// A pending digest does not block input.
// ----------------------------------------------------------------------------
module siphash_2_4_stream
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [63:0]         message_word,
    input  logic [3:0]          byte_count,
    input  logic                last_word,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         digest
);
    import sip_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_ROUND
    } seq_state_t;

    seq_state_t state_reg,     state_next;
    word_t      key_low_reg,   key_low_next;
    word_t      key_high_reg,  key_high_next;
    state_t     v_reg,         v_next;
    word_t      blk_reg,       blk_next;
    logic [7:0] len_reg,       len_next;
    logic       mid_reg,       mid_next;
    logic       last_reg,      last_next;
    logic       extra_reg,     extra_next;
    logic       fin_reg,       fin_next;
    logic [2:0] rnd_left_reg,  rnd_left_next;
    logic       out_valid_reg, out_valid_next;
    word_t      digest_reg,    digest_next;

    state_t     rnd_out;
    state_t     start_v;
    logic [3:0] cnt_sat;
    logic       full_word;
    logic [7:0] len_add;
    word_t      len_blk;
    logic       in_xfer;

    // Shared round unit
    sip_round u_round
    (
        .v_in  (v_reg),
        .v_out (rnd_out)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign digest    = digest_reg;

    // Decode the incoming item
    always_comb
    begin
        cnt_sat    = byte_count[3] ? 4'd8 : byte_count;
        full_word  = !last_word || (cnt_sat == 4'd8);
        start_v[0] = key_low_reg  ^ SIP_C0;
        start_v[1] = key_high_reg ^ SIP_C1;
        start_v[2] = key_low_reg  ^ SIP_C2;
        start_v[3] = key_high_reg ^ SIP_C3;
        if (mid_reg)
        begin
            start_v = v_reg;
        end
        len_add = (mid_reg ? len_reg : 8'd0) + (full_word ? 8'd8 : {4'd0, cnt_sat});
        len_blk = {len_reg, 56'd0};
    end

    // Next-state logic of the sequencer
    always_comb
    begin
        state_next     = state_reg;
        key_low_next   = key_low_reg;
        key_high_next  = key_high_reg;
        v_next         = v_reg;
        blk_next       = blk_reg;
        len_next       = len_reg;
        mid_next       = mid_reg;
        last_next      = last_reg;
        extra_next     = extra_reg;
        fin_next       = fin_reg;
        rnd_left_next  = rnd_left_reg;
        out_valid_next = out_valid_reg;
        digest_next    = digest_reg;

        // Key writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:  key_low_next  = cfg_data;
                CFG_KEY_HIGH: key_high_next = cfg_data;
                default:      key_low_next  = key_low_reg;
            endcase
        end

        // Drop the digest once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    blk_next = full_word ? message_word
                             : ((message_word & low_bytes(cnt_sat)) | {len_add, 56'd0});
                    v_next        = start_v;
                    v_next[3]     = start_v[3] ^ blk_next;
                    len_next      = len_add;
                    mid_next      = 1'b1;
                    last_next     = last_word;
                    extra_next    = last_word && full_word;
                    fin_next      = 1'b0;
                    rnd_left_next = C_ROUNDS;
                    state_next    = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                if (rnd_left_reg != 3'd1)
                begin
                    // Advance one round
                    v_next        = rnd_out;
                    rnd_left_next = rnd_left_reg - 3'd1;
                end
                else if (!fin_reg)
                begin
                    // Close the absorbed block
                    v_next    = rnd_out;
                    v_next[0] = rnd_out[0] ^ blk_reg;
                    if (!last_reg)
                    begin
                        rnd_left_next = 3'd0;
                        state_next    = ST_IDLE;
                    end
                    else if (extra_reg)
                    begin
                        blk_next      = len_blk;
                        v_next[3]     = rnd_out[3] ^ len_blk;
                        extra_next    = 1'b0;
                        rnd_left_next = C_ROUNDS;
                    end
                    else
                    begin
                        v_next[2]     = rnd_out[2] ^ SIP_FIN_XOR;
                        fin_next      = 1'b1;
                        rnd_left_next = D_ROUNDS;
                    end
                end
                else if (!out_valid_reg || out_ready)
                begin
                    // Last finalization round: load the digest
                    v_next         = rnd_out;
                    digest_next    = rnd_out[0] ^ rnd_out[1] ^ rnd_out[2] ^ rnd_out[3];
                    out_valid_next = 1'b1;
                    mid_next       = 1'b0;
                    len_next       = 8'd0;
                    fin_next       = 1'b0;
                    rnd_left_next  = 3'd0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            v_reg         <= '0;
            blk_reg       <= '0;
            len_reg       <= '0;
            mid_reg       <= 1'b0;
            last_reg      <= 1'b0;
            extra_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            rnd_left_reg  <= '0;
            out_valid_reg <= 1'b0;
            digest_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            key_low_reg   <= key_low_next;
            key_high_reg  <= key_high_next;
            v_reg         <= v_next;
            blk_reg       <= blk_next;
            len_reg       <= len_next;
            mid_reg       <= mid_next;
            last_reg      <= last_next;
            extra_reg     <= extra_next;
            fin_reg       <= fin_next;
            rnd_left_reg  <= rnd_left_next;
            out_valid_reg <= out_valid_next;
            digest_reg    <= digest_next;
        end
    end

`ifndef SYNTH
    // An accepted item keeps the block busy in the next cycle
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous item still in progress");

    // The round counter is idle outside the round state
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (rnd_left_reg == 3'd0))
        else $error("round counter nonzero while idle");

    // A digest appears only after finalization rounds
    a_digest_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fin_reg))
        else $error("digest loaded outside finalization");

    // Loading a digest ends the message
    a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> !mid_reg && (len_reg == 8'd0))
        else $error("message state not cleared with digest");
`endif

endmodule

FILE: rtl/sip_round.sv
// ----------------------------------------------------------------------------
// sip_round
// One SipRound on the four chain words: add, rotate, XOR in two half rounds.
// The sequencer in the top level reuses this unit for every round.
// ----------------------------------------------------------------------------
module sip_round
(
    input  sip_pkg::state_t v_in,
    output sip_pkg::state_t v_out
);
    import sip_pkg::*;

    word_t a0;
    word_t a2;
    word_t b1;
    word_t b3;
    word_t c0;
    word_t d0;
    word_t d2;
    word_t e1;
    word_t e3;
    word_t f2;

    // First half round: both lanes in parallel
    assign a0 = v_in[0] + v_in[1];
    assign b1 = {v_in[1][50:0], v_in[1][63:51]} ^ a0;
    assign c0 = {a0[31:0], a0[63:32]};
    assign a2 = v_in[2] + v_in[3];
    assign b3 = {v_in[3][47:0], v_in[3][63:48]} ^ a2;

    // Second half round: cross the lanes
    assign d0 = c0 + b3;
    assign e3 = {b3[42:0], b3[63:43]} ^ d0;
    assign d2 = a2 + b1;
    assign e1 = {b1[46:0], b1[63:47]} ^ d2;
    assign f2 = {d2[31:0], d2[63:32]};

    assign v_out[0] = d0;
    assign v_out[1] = e1;
    assign v_out[2] = f2;
    assign v_out[3] = e3;

endmodule
